// File: sv/abad_pkg.sv
// Shared constants, codes and control/status structs for the adaptive binary
// arithmetic decoder. No dependencies.
`timescale 1ns / 1ps

package abad_pkg;

   // context model
   localparam int CONTEXT_BITS = 8;
   localparam int CTX_COUNT    = 1 << CONTEXT_BITS;
   localparam int CNT_W        = 28;
   localparam int PAIR_W       = 2 * CNT_W;
   localparam logic [CNT_W-1:0] CNT_LIMIT = 28'hFFFFFFF;

   // interval and probability
   localparam int RANGE_W = 64;
   localparam int PROB_W  = 32;
   localparam logic [PROB_W-1:0] PROB_RESET = 32'hFFFFFFFF;
   localparam logic [7:0] FILL_BYTE = 8'hFF;

   // divider: divisor c0 + c1 + 2 fits CNT_W + 2 bits, quotient below 2^32
   localparam int DEN_W  = CNT_W + 2;
   localparam int QUO_W  = PROB_W;
   localparam int STEP_W = $clog2(QUO_W + 1);

   // owed-byte bookkeeping
   localparam int OWED_W = 4;
   localparam logic [OWED_W-1:0] MAX_SHIFTS = 4'd8;

   // word kinds on the request side
   localparam logic REQ_BYTE   = 1'b0;
   localparam logic REQ_DECODE = 1'b1;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_REFUSED = 2'd1,
      ST_IGNORED = 2'd2
   } rsp_status_type;

   typedef enum logic [9:0] {
      S_IDLE   = 10'b00_0000_0001,
      S_DIFF   = 10'b00_0000_0010,
      S_MUL    = 10'b00_0000_0100,
      S_SPLIT  = 10'b00_0000_1000,
      S_BITSEL = 10'b00_0001_0000,
      S_UPDATE = 10'b00_0010_0000,
      S_READ   = 10'b00_0100_0000,
      S_LOAD   = 10'b00_1000_0000,
      S_DIV    = 10'b01_0000_0000,
      S_RESP   = 10'b10_0000_0000
   } state_type;

   typedef struct packed {
      logic take_byte;
      logic ignore_byte;
      logic refuse;
      logic diff;
      logic mul;
      logic split;
      logic bitsel;
      logic update;
      logic rd_ctx;
      logic div_start;
      logic renorm;
      logic finish;
      logic out_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic pending_zero;
      logic div_busy;
      logic renorm_done;
   } dp_status_type;

endpackage

// File: sv/abad_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module abad_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/abad_div.sv
// Restoring divider for the probability update: ((c1 + 1) << 32) / (c0 + c1 + 2),
// one quotient bit per cycle. Depends on abad_pkg.
`timescale 1ns / 1ps

module abad_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [abad_pkg::CNT_W-1:0]   cnt0,
   input  logic [abad_pkg::CNT_W-1:0]   cnt1,
   output logic                         busy,
   output logic [abad_pkg::QUO_W-1:0]   quotient
);

   logic [abad_pkg::DEN_W-1:0]  den_ff, den_in;
   logic [abad_pkg::DEN_W-1:0]  rem_ff, rem_in;
   logic [abad_pkg::QUO_W-1:0]  quo_ff, quo_in;
   logic [abad_pkg::STEP_W-1:0] step_ff, step_in;
   logic                        busy_ff, busy_in;
   logic [abad_pkg::DEN_W:0]    shifted;
   logic [abad_pkg::DEN_W:0]    trial;
   logic                        qbit;

   always_comb begin
      shifted = {rem_ff, 1'b0};
      trial   = shifted - {1'b0, den_ff};
      qbit    = (shifted >= {1'b0, den_ff});
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      if (start) begin
         // numerator's top part is c1 + 1, always below the divisor
         den_in  = abad_pkg::DEN_W'(cnt0) + abad_pkg::DEN_W'(cnt1) + abad_pkg::DEN_W'(2);
         rem_in  = abad_pkg::DEN_W'(cnt1) + abad_pkg::DEN_W'(1);
         quo_in  = '0;
         step_in = abad_pkg::STEP_W'(abad_pkg::QUO_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = qbit ? trial[abad_pkg::DEN_W-1:0] : shifted[abad_pkg::DEN_W-1:0];
         quo_in  = {quo_ff[abad_pkg::QUO_W-2:0], qbit};
         step_in = step_ff - abad_pkg::STEP_W'(1);
         busy_in = (step_ff != abad_pkg::STEP_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

// File: sv/abad_dp.sv
// Decoder datapath: interval registers, split multiply, count store, renormaliser,
// probability divider and result registers. Depends on abad_pkg, abad_ram, abad_div.
`timescale 1ns / 1ps

module abad_dp (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [7:0]                     req_byte,
   input  abad_pkg::ctrl_cmd_type         cmd,
   output abad_pkg::dp_status_type        status,
   output logic                           rsp_bit,
   output logic [abad_pkg::OWED_W-1:0]    rsp_owed,
   output logic [1:0]                     rsp_status
);

   localparam int RW = abad_pkg::RANGE_W;
   localparam int CB = abad_pkg::CONTEXT_BITS;
   localparam int CW = abad_pkg::CNT_W;
   localparam int OW = abad_pkg::OWED_W;

   // architectural state
   logic [RW-1:0]                 low_ff, low_in;
   logic [RW-1:0]                 high_ff, high_in;
   logic [RW-1:0]                 code_ff, code_in;
   logic [CB-1:0]                 ctx_ff, ctx_in;
   logic [abad_pkg::PROB_W-1:0]   prob_ff, prob_in;
   logic [OW-1:0]                 pending_ff, pending_in;
   logic [abad_pkg::CTX_COUNT-1:0] valid_ff, valid_in;

   // working registers
   logic [RW-1:0]                 diff_ff, diff_in;
   logic [RW-1:0]                 prod_ff, prod_in;
   logic [RW-1:0]                 split_ff, split_in;
   logic                          bit_ff, bit_in;
   logic [OW-1:0]                 ren_cnt_ff, ren_cnt_in;
   logic                          rd_valid_ff, rd_valid_in;

   // result and output registers
   logic                          res_bit_ff, res_bit_in;
   logic [OW-1:0]                 res_owed_ff, res_owed_in;
   abad_pkg::rsp_status_type      res_status_ff, res_status_in;
   logic                          out_bit_ff, out_bit_in;
   logic [OW-1:0]                 out_owed_ff, out_owed_in;
   abad_pkg::rsp_status_type      out_status_ff, out_status_in;

   logic [abad_pkg::PAIR_W-1:0]   rd_pair;
   logic [abad_pkg::PAIR_W-1:0]   pair;
   logic [abad_pkg::PAIR_W-1:0]   wr_pair;
   logic [CW-1:0]                 c0, c1;
   logic [CW:0]                   c0_inc, c1_inc;
   logic [CW-1:0]                 c0_new, c1_new;
   logic [CB-1:0]                 ctx_ext;
   logic                          renorm_done;
   logic                          div_busy;
   logic [abad_pkg::QUO_W-1:0]    quotient;

   abad_ram #(
      .WIDTH (abad_pkg::PAIR_W),
      .DEPTH (abad_pkg::CTX_COUNT)
   ) u_counts (
      .clock   (clock),
      .wr_en   (cmd.update),
      .wr_addr (ctx_ff),
      .wr_data (wr_pair),
      .rd_en   (cmd.rd_ctx),
      .rd_addr (ctx_ff),
      .rd_data (rd_pair)
   );

   abad_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .cnt0     (c0),
      .cnt1     (c1),
      .busy     (div_busy),
      .quotient (quotient)
   );

   // a context never written reads as a zero pair
   assign pair = rd_valid_ff ? rd_pair : '0;
   assign c0   = pair[CW-1:0];
   assign c1   = pair[2*CW-1:CW];

   always_comb begin
      c0_inc = {1'b0, c0} + (CW+1)'(!bit_ff);
      c1_inc = {1'b0, c1} + (CW+1)'(bit_ff);
      if ((c0_inc > {1'b0, abad_pkg::CNT_LIMIT}) || (c1_inc > {1'b0, abad_pkg::CNT_LIMIT})) begin
         c0_new = c0_inc[CW:1];
         c1_new = c1_inc[CW:1];
      end else begin
         c0_new = c0_inc[CW-1:0];
         c1_new = c1_inc[CW-1:0];
      end
      wr_pair = {c1_new, c0_new};
   end

   assign ctx_ext     = {ctx_ff[CB-2:0], bit_ff};
   assign renorm_done = (ren_cnt_ff == abad_pkg::MAX_SHIFTS) ||
                        (low_ff[RW-1:RW-8] != high_ff[RW-1:RW-8]);

   always_comb begin
      low_in        = low_ff;
      high_in       = high_ff;
      code_in       = code_ff;
      ctx_in        = ctx_ff;
      prob_in       = prob_ff;
      pending_in    = pending_ff;
      valid_in      = valid_ff;
      diff_in       = diff_ff;
      prod_in       = prod_ff;
      split_in      = split_ff;
      bit_in        = bit_ff;
      ren_cnt_in    = ren_cnt_ff;
      rd_valid_in   = rd_valid_ff;
      res_bit_in    = res_bit_ff;
      res_owed_in   = res_owed_ff;
      res_status_in = res_status_ff;
      out_bit_in    = out_bit_ff;
      out_owed_in   = out_owed_ff;
      out_status_in = out_status_ff;

      if (cmd.take_byte) begin
         code_in       = {code_ff[RW-9:0], req_byte};
         pending_in    = pending_ff - OW'(1);
         res_bit_in    = 1'b0;
         res_owed_in   = pending_ff - OW'(1);
         res_status_in = abad_pkg::ST_OK;
      end
      if (cmd.ignore_byte) begin
         res_bit_in    = 1'b0;
         res_owed_in   = pending_ff;
         res_status_in = abad_pkg::ST_IGNORED;
      end
      if (cmd.refuse) begin
         res_bit_in    = 1'b0;
         res_owed_in   = pending_ff;
         res_status_in = abad_pkg::ST_REFUSED;
      end
      if (cmd.rd_ctx) begin
         rd_valid_in = valid_ff[ctx_ff];
      end
      if (cmd.diff) begin
         diff_in = high_ff - low_ff;
      end
      if (cmd.mul) begin
         // 32 x 32 product, full 64 bits kept
         prod_in = {32'd0, diff_ff[RW-1:RW-32]} * {32'd0, prob_ff};
      end
      if (cmd.split) begin
         split_in = low_ff + prod_ff;
      end
      if (cmd.bitsel) begin
         bit_in     = (code_ff <= split_ff);
         ren_cnt_in = '0;
         if (code_ff <= split_ff) begin
            high_in = split_ff;
         end else begin
            low_in = split_ff + RW'(1);
         end
      end
      if (cmd.update) begin
         valid_in[ctx_ff] = 1'b1;
         ctx_in           = ctx_ext;
      end
      if (cmd.renorm && !renorm_done) begin
         low_in     = {low_ff[RW-9:0], 8'h00};
         high_in    = {high_ff[RW-9:0], abad_pkg::FILL_BYTE};
         ren_cnt_in = ren_cnt_ff + OW'(1);
      end
      if (cmd.finish) begin
         prob_in       = quotient;
         pending_in    = ren_cnt_ff;
         res_bit_in    = bit_ff;
         res_owed_in   = ren_cnt_ff;
         res_status_in = abad_pkg::ST_OK;
      end
      if (cmd.out_load) begin
         out_bit_in    = res_bit_ff;
         out_owed_in   = res_owed_ff;
         out_status_in = res_status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff     <= '0;
         high_ff    <= '1;
         code_ff    <= '0;
         ctx_ff     <= '0;
         prob_ff    <= abad_pkg::PROB_RESET;
         pending_ff <= abad_pkg::MAX_SHIFTS;
         valid_ff   <= '0;
         ren_cnt_ff <= '0;
      end else begin
         low_ff     <= low_in;
         high_ff    <= high_in;
         code_ff    <= code_in;
         ctx_ff     <= ctx_in;
         prob_ff    <= prob_in;
         pending_ff <= pending_in;
         valid_ff   <= valid_in;
         ren_cnt_ff <= ren_cnt_in;
      end
      diff_ff       <= diff_in;
      prod_ff       <= prod_in;
      split_ff      <= split_in;
      bit_ff        <= bit_in;
      rd_valid_ff   <= rd_valid_in;
      res_bit_ff    <= res_bit_in;
      res_owed_ff   <= res_owed_in;
      res_status_ff <= res_status_in;
      out_bit_ff    <= out_bit_in;
      out_owed_ff   <= out_owed_in;
      out_status_ff <= out_status_in;
   end

   assign status.pending_zero = (pending_ff == '0);
   assign status.div_busy     = div_busy;
   assign status.renorm_done  = renorm_done;

   assign rsp_bit    = out_bit_ff;
   assign rsp_owed   = out_owed_ff;
   assign rsp_status = out_status_ff;

endmodule

// File: sv/abad_ctrl.sv
// Decoder controller: one-hot sequencer issuing datapath commands and owning
// both handshakes. Depends on abad_pkg.
`timescale 1ns / 1ps

module abad_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   input  logic                      req_type,
   input  logic                      rsp_tready,
   input  abad_pkg::dp_status_type   status,
   output logic                      req_tready,
   output logic                      rsp_tvalid,
   output abad_pkg::ctrl_cmd_type    cmd
);

   abad_pkg::state_type state_ff, state_in;
   logic                out_valid_ff, out_valid_in;
   logic                slot_free;

   assign slot_free = !out_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         abad_pkg::S_IDLE: begin
            if (req_tvalid) begin
               if (req_type == abad_pkg::REQ_DECODE) begin
                  if (status.pending_zero) begin
                     cmd.diff   = 1'b1;
                     cmd.rd_ctx = 1'b1;
                     state_in   = abad_pkg::S_MUL;
                  end else begin
                     cmd.refuse = 1'b1;
                     state_in   = abad_pkg::S_RESP;
                  end
               end else begin
                  cmd.take_byte   = !status.pending_zero;
                  cmd.ignore_byte = status.pending_zero;
                  state_in        = abad_pkg::S_RESP;
               end
            end
         end
         abad_pkg::S_DIFF: begin
            cmd.diff   = 1'b1;
            cmd.rd_ctx = 1'b1;
            state_in   = abad_pkg::S_MUL;
         end
         abad_pkg::S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = abad_pkg::S_SPLIT;
         end
         abad_pkg::S_SPLIT: begin
            cmd.split = 1'b1;
            state_in  = abad_pkg::S_BITSEL;
         end
         abad_pkg::S_BITSEL: begin
            cmd.bitsel = 1'b1;
            state_in   = abad_pkg::S_UPDATE;
         end
         abad_pkg::S_UPDATE: begin
            cmd.update = 1'b1;
            cmd.renorm = 1'b1;
            state_in   = abad_pkg::S_READ;
         end
         abad_pkg::S_READ: begin
            cmd.rd_ctx = 1'b1;
            cmd.renorm = 1'b1;
            state_in   = abad_pkg::S_LOAD;
         end
         abad_pkg::S_LOAD: begin
            cmd.div_start = 1'b1;
            cmd.renorm    = 1'b1;
            state_in      = abad_pkg::S_DIV;
         end
         abad_pkg::S_DIV: begin
            cmd.renorm = 1'b1;
            if (!status.div_busy && status.renorm_done) begin
               cmd.finish = 1'b1;
               state_in   = abad_pkg::S_RESP;
            end
         end
         abad_pkg::S_RESP: begin
            if (slot_free) begin
               cmd.out_load = 1'b1;
               state_in     = abad_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = abad_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= abad_pkg::S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign req_tready = (state_ff == abad_pkg::S_IDLE);
   assign rsp_tvalid = out_valid_ff;

endmodule

// File: sv/adaptive_binary_arithmetic_decoder.sv
// Top level of the adaptive binary arithmetic decoder: controller, datapath
// and port packing. Depends on abad_pkg, abad_ctrl, abad_dp.
`timescale 1ns / 1ps

// Usage
//   req channel: one word per request. req_tuser = 0 supplies a compressed byte
//   in req_tdata (feed 0 past end of stream), req_tuser = 1 asks for one bit.
//   rsp channel: exactly one word per request, in order: decoded bit, bytes
//   still owed and a status (ok / decode refused while bytes owed / byte not
//   needed). After reset eight bytes are owed before the first decode.
// Sequencing
//   Byte and refused/ignored words: result registered on acceptance, then
//   loaded into the output register once it is free; the next word follows.
//   Decode: interval difference and count read on acceptance, multiply, split,
//   bit select, count update, count read for the new context, then the 32-step
//   divider at one quotient bit per cycle, then finish and output load; the
//   next word follows. Renormalisation (up to 8 shifts) runs under the divider.
// Reset
//   Synchronous. Interval, code, context and probability go to their start
//   values; a valid bit per context makes the whole count store read zero
//   at once, so no clearing pass is needed.
// Stalls
//   The result sits in an output register. If rsp_tready is low the block
//   still finishes and parks the next result internally; it only stops
//   taking words once both are held.
module adaptive_binary_arithmetic_decoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] byte_in
   input  logic       req_tuser,   // [0] req_type
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [0] bit_out, [4:1] bytes_owed, [7:5] zero
   output logic [1:0] rsp_tuser    // [1:0] status
);

   abad_pkg::ctrl_cmd_type            cmd;
   abad_pkg::dp_status_type           dp_status;
   logic                              rsp_bit;
   logic [abad_pkg::OWED_W-1:0]       rsp_owed;
   logic [1:0]                        rsp_status;

   abad_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_type   (req_tuser),
      .rsp_tready (rsp_tready),
      .status     (dp_status),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .cmd        (cmd)
   );

   abad_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_byte   (req_tdata),
      .cmd        (cmd),
      .status     (dp_status),
      .rsp_bit    (rsp_bit),
      .rsp_owed   (rsp_owed),
      .rsp_status (rsp_status)
   );

   assign rsp_tdata = {3'b000, rsp_owed, rsp_bit};
   assign rsp_tuser = rsp_status;

   // never more than eight bytes owed
   a_owed_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[4:1] <= abad_pkg::MAX_SHIFTS))
      else $error("bytes_owed above eight");

   // a refused decode only happens while bytes are owed
   a_refused_owed: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == abad_pkg::ST_REFUSED) |-> (rsp_tdata[4:1] != 4'd0))
      else $error("decode refused with nothing owed");

   // an ignored byte means nothing owed and no bit
   a_ignored_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == abad_pkg::ST_IGNORED) |->
         (rsp_tdata[4:1] == 4'd0 && rsp_tdata[0] == 1'b0))
      else $error("ignored byte with bytes owed or bit set");

   // one word in flight: the request side closes straight after acceptance
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second word accepted while one is in progress");

endmodule
